// ===== hdl/dlpl_pkg.sv =====
// Shared types and constants for the longest-path level unit.
// Holds the controller/datapath command and status structs; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dlpl_pkg;

  localparam int unsigned MaxNodesDef = 64;
  localparam int unsigned LabelW      = 7;

  typedef struct packed {
    logic capture;      // latch the input beat
    logic walk_rd;      // read address from the scan index, else the edge source
    logic mem_rd;       // issue a row read
    logic mem_wr;       // merge the edge bit into its row
    logic walk_init;    // seed the first level set
    logic row_acc;      // fold the row just read into the next level set
    logic level_step;   // advance to the next level set
    logic load_result;  // move the result into the output register
    logic result_cyc;   // cycle flag that goes with load_result
  } cmd_t;

  typedef struct packed {
    logic is_last;
    logic edge_ok;
    logic n_zero;
    logic row_last;
    logic next_empty;
    logic level_eq_n;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== hdl/dag_longest_path_levels_unit.sv =====
// Top level of the longest-path level unit: controller plus datapath.
// Depends on dlpl_pkg, dlpl_ctrl and dlpl_dp.
`timescale 1ns / 1ps
`default_nettype none
//
//  channel  handshake               payload
//  in       in_valid_i/in_ready_o    from_node_i, to_node_i, has_edge_i, last_item_i
//  out      out_valid_o/out_ready_i  semesters_o, cycle_found_o
//  cfg      cfg_valid_i/cfg_ready_o  cfg_data_i (node_count)
//
// Each edge beat passes through capture, row read and row write-back in turn
// (one port on the adjacency memory sets the pace).
// After a last_item beat the walk builds level sets S1, S2, ...: each level
// reads every live row once, each row read followed by an accumulate step,
// and ends with one evaluation step.
// Reset clears the row valid bits, so the adjacency store needs no sweep;
// they clear again, all together, when a result is loaded.
// A waiting result holds the controller in its result state; the next
// beat is taken once the result register frees up.
module dag_longest_path_levels_unit #(
  parameter int unsigned MAX_NODES = dlpl_pkg::MaxNodesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dlpl_pkg::LabelW-1:0] from_node_i,
  input  logic [dlpl_pkg::LabelW-1:0] to_node_i,
  input  logic                        has_edge_i,
  input  logic                        last_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [dlpl_pkg::LabelW-1:0] semesters_o,
  output logic                        cycle_found_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [dlpl_pkg::LabelW-1:0] cfg_data_i
);
  import dlpl_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // Configuration beats are always taken; hold the node count steady while
  // a graph is loading or being walked.
  assign cfg_ready_o = 1'b1;

  dlpl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dlpl_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .from_node_i   (from_node_i),
    .to_node_i     (to_node_i),
    .has_edge_i    (has_edge_i),
    .last_item_i   (last_item_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .semesters_o   (semesters_o),
    .cycle_found_o (cycle_found_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

`ifndef ASSERT_OFF
  a_cycle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cycle_found_o |-> semesters_o == '0)
    else $error("cycle result carries a nonzero length");
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !cycle_found_o |-> semesters_o != '0)
    else $error("acyclic result with zero length");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second beat accepted before the first finished");
`endif

endmodule
`default_nettype wire

// ===== hdl/dlpl_ctrl.sv =====
// Controller state machine for the longest-path level unit.
// Depends on dlpl_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none
module dlpl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dlpl_pkg::status_t sts_i,
  output dlpl_pkg::cmd_t    cmd_o
);
  import dlpl_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LDRD = 3'd1;
  localparam logic [2:0] S_LDWR = 3'd2;
  localparam logic [2:0] S_WRD  = 3'd3;
  localparam logic [2:0] S_WAC  = 3'd4;
  localparam logic [2:0] S_WEV  = 3'd5;
  localparam logic [2:0] S_RES  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       cyc_q, cyc_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cyc_d   = cyc_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_LDRD;
        end
      end
      S_LDRD: begin
        cmd_o.mem_rd = 1'b1;
        state_d = S_LDWR;
      end
      S_LDWR: begin
        cmd_o.mem_wr = sts_i.edge_ok;
        if (sts_i.is_last) begin
          cmd_o.walk_init = 1'b1;
          cyc_d = 1'b0;
          state_d = sts_i.n_zero ? S_RES : S_WRD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_WRD: begin
        cmd_o.walk_rd = 1'b1;
        cmd_o.mem_rd  = 1'b1;
        state_d = S_WAC;
      end
      S_WAC: begin
        cmd_o.row_acc = 1'b1;
        state_d = sts_i.row_last ? S_WEV : S_WRD;
      end
      S_WEV: begin
        if (sts_i.next_empty) begin
          cyc_d = 1'b0;
          state_d = S_RES;
        end else if (sts_i.level_eq_n) begin
          cyc_d = 1'b1;
          state_d = S_RES;
        end else begin
          cmd_o.level_step = 1'b1;
          state_d = S_WRD;
        end
      end
      S_RES: begin
        if (sts_i.out_free) begin
          cmd_o.load_result = 1'b1;
          cmd_o.result_cyc  = cyc_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cyc_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cyc_q   <= cyc_d;
    end
  end

`ifndef ASSERT_OFF
  a_wev_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WEV |=> state_q == S_WRD || state_q == S_RES)
    else $error("level evaluation left to an unexpected state");
  a_step_needs_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.level_step |-> !sts_i.next_empty && !sts_i.level_eq_n)
    else $error("level advanced past a terminal condition");
  a_capture_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |-> state_q == S_IDLE && !cmd_o.load_result)
    else $error("beat captured outside idle");
`endif

endmodule
`default_nettype wire

// ===== hdl/dlpl_dp.sv =====
// Datapath for the longest-path level unit: adjacency memory, level sets,
// node count register and result register. Depends on dlpl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dlpl_dp #(
  parameter int unsigned MAX_NODES = dlpl_pkg::MaxNodesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [dlpl_pkg::LabelW-1:0]   cfg_data_i,
  input  logic [dlpl_pkg::LabelW-1:0]   from_node_i,
  input  logic [dlpl_pkg::LabelW-1:0]   to_node_i,
  input  logic                          has_edge_i,
  input  logic                          last_item_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [dlpl_pkg::LabelW-1:0]   semesters_o,
  output logic                          cycle_found_o,
  input  dlpl_pkg::cmd_t                cmd_i,
  output dlpl_pkg::status_t             sts_o
);
  import dlpl_pkg::*;

  localparam int unsigned NW = $clog2(MAX_NODES);
  localparam int unsigned CW = $clog2(MAX_NODES + 1);
  localparam int unsigned LW = (CW > LabelW) ? CW : LabelW;
  localparam int unsigned SatMax = (1 << LabelW) - 1;

  logic [LabelW-1:0] ncount_q;
  logic [LabelW-1:0] from_q, to_q;
  logic              edge_q, last_q;
  logic [CW-1:0]     n_eff;
  logic [LW-1:0]     nc_ext, from_ext, to_ext, n_ext;
  logic [NW-1:0]     from_idx, to_idx, rd_addr;

  logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
  logic [MAX_NODES-1:0] row_valid_q;
  logic [MAX_NODES-1:0] rd_row_q;
  logic                 rd_vld_q;

  logic [MAX_NODES-1:0] cur_q, nxt_q, live_mask;
  logic [CW-1:0]        level_q;
  logic [NW-1:0]        scan_q;

  logic                 out_valid_q, out_cyc_q;
  logic [LabelW-1:0]    out_sem_q;

  assign nc_ext   = LW'(ncount_q);
  assign n_eff    = (nc_ext > LW'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(nc_ext);
  assign n_ext    = LW'(n_eff);
  assign from_ext = LW'(from_q);
  assign to_ext   = LW'(to_q);
  assign from_idx = NW'(from_ext - LW'(1));
  assign to_idx   = NW'(to_ext - LW'(1));
  assign rd_addr  = cmd_i.walk_rd ? scan_q : from_idx;

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      live_mask[i] = (CW'(i) < n_eff);
    end
  end

  assign sts_o.is_last    = last_q;
  assign sts_o.edge_ok    = edge_q && (from_q != '0) && (to_q != '0)
                            && (from_ext <= n_ext) && (to_ext <= n_ext);
  assign sts_o.n_zero     = (n_eff == '0);
  assign sts_o.row_last   = (CW'(scan_q) == n_eff - CW'(1));
  assign sts_o.next_empty = (nxt_q == '0);
  assign sts_o.level_eq_n = (level_q == n_eff);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncount_q    <= LabelW'(1);
      row_valid_q <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) ncount_q <= cfg_data_i;
      if (cmd_i.mem_rd) rd_vld_q <= row_valid_q[rd_addr];
      if (cmd_i.load_result) begin
        row_valid_q <= '0;
        out_valid_q <= 1'b1;
      end else begin
        if (cmd_i.mem_wr) row_valid_q[from_idx] <= 1'b1;
        if (out_ready_i) out_valid_q <= 1'b0;
      end
    end
  end

  // Adjacency memory: one row port, registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd) rd_row_q <= adj_mem[rd_addr];
    if (cmd_i.mem_wr) begin
      adj_mem[from_idx] <= (rd_vld_q ? rd_row_q : '0)
                           | (MAX_NODES'(1) << to_idx);
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      from_q <= from_node_i;
      to_q   <= to_node_i;
      edge_q <= has_edge_i;
      last_q <= last_item_i;
    end
    if (cmd_i.walk_init) begin
      cur_q   <= live_mask;
      nxt_q   <= '0;
      level_q <= CW'(1);
      scan_q  <= '0;
    end else if (cmd_i.level_step) begin
      cur_q   <= nxt_q;
      nxt_q   <= '0;
      level_q <= level_q + CW'(1);
      scan_q  <= '0;
    end else if (cmd_i.row_acc) begin
      nxt_q[scan_q] <= rd_vld_q && ((rd_row_q & cur_q) != '0);
      scan_q        <= sts_o.row_last ? '0 : scan_q + NW'(1);
    end
    if (cmd_i.load_result) begin
      out_cyc_q <= cmd_i.result_cyc;
      if (cmd_i.result_cyc) out_sem_q <= '0;
      else if (LW'(level_q) > LW'(SatMax)) out_sem_q <= LabelW'(SatMax);
      else out_sem_q <= LabelW'(level_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign semesters_o   = out_sem_q;
  assign cycle_found_o = out_cyc_q;

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Testbench for dag_longest_path_levels_unit: loads random and directed graphs,
// predicts the longest path or cycle flag, and checks every result beat.
// Depends on dlpl_pkg and the unit's RTL.
`timescale 1ns / 1ps
module testbench;
  import dlpl_pkg::*;

  localparam int unsigned NMax = MaxNodesDef;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [LabelW-1:0] from_node_i = '0;
  logic [LabelW-1:0] to_node_i = '0;
  logic has_edge_i = 1'b0;
  logic last_item_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [LabelW-1:0] semesters_o;
  logic cycle_found_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [LabelW-1:0] cfg_data_i = '0;

  typedef struct packed {
    logic [LabelW-1:0] semesters;
    logic              cycle_found;
  } path_result_t;

  // Predictor state: the graph being loaded and the node count.
  logic [NMax-1:0] arc_rows [NMax];
  int unsigned     node_cnt;
  path_result_t    pending_paths [$];
  int unsigned     mismatch_cnt;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;

  dag_longest_path_levels_unit i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .from_node_i, .to_node_i,
    .has_edge_i, .last_item_i, .out_valid_o, .out_ready_i, .semesters_o,
    .cycle_found_o, .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop; well above ~1900 beats each closing a 64-node cycle walk.
  initial begin
    #1000ms;
    $display("Mismatches found");
    $finish;
  end

  // Memoized longest path from node u (counted in nodes); flags a cycle.
  int path_len [NMax];
  bit on_route [NMax];
  bit saw_cycle;

  function automatic int longest_from_node(int u, int n);
    int best;
    int cand;
    if (path_len[u] != 0) return path_len[u];
    on_route[u] = 1'b1;
    best = 1;
    for (int v = 0; v < n; v++) begin
      if (saw_cycle) break;
      if (arc_rows[u][v]) begin
        if (on_route[v]) begin
          saw_cycle = 1'b1;
        end else begin
          cand = longest_from_node(v, n) + 1;
          if (cand > best) best = cand;
        end
      end
    end
    on_route[u] = 1'b0;
    path_len[u] = best;
    return best;
  endfunction

  function automatic path_result_t close_graph();
    path_result_t res;
    int n;
    int best;
    int len;
    n = (node_cnt > NMax) ? NMax : node_cnt;
    best = 1;
    saw_cycle = 1'b0;
    foreach (path_len[i]) begin
      path_len[i] = 0;
      on_route[i] = 1'b0;
    end
    for (int r = 0; r < n && !saw_cycle; r++) begin
      len = longest_from_node(r, n);
      if (len > best) best = len;
    end
    if (saw_cycle) begin
      res.semesters = '0;
      res.cycle_found = 1'b1;
    end else begin
      res.semesters = (best > 127) ? 7'd127 : best[LabelW-1:0];
      res.cycle_found = 1'b0;
    end
    foreach (arc_rows[i]) arc_rows[i] = '0;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH %s", $realtime, what);
    mismatch_cnt++;
  endtask

  // Send one beat; predict on acceptance. Valid stays high after acceptance
  // until the next beat, an idle cycle or a drain drops it.
  task automatic send_edge(input int a, input int b, input bit he, input bit last);
    int n;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    from_node_i <= a[LabelW-1:0];
    to_node_i   <= b[LabelW-1:0];
    has_edge_i  <= he;
    last_item_i <= last;
    in_valid_i  <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    n = (node_cnt > NMax) ? NMax : node_cnt;
    if (he && a >= 1 && a <= n && b >= 1 && b <= n) arc_rows[a-1][b-1] = 1'b1;
    if (last) pending_paths.insert(pending_paths.size(), close_graph());
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_paths.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_node_count(input int value);
    drain_results();
    cfg_data_i  <= value[LabelW-1:0];
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    node_cnt = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver: random stalls, check each result beat against the oldest prediction.
  always @(posedge clk_i) begin
    path_result_t exp_res;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_paths.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          exp_res = pending_paths.pop_front();
          if (semesters_o !== exp_res.semesters)
            report_mismatch($sformatf("semesters got %0d exp %0d",
                                      semesters_o, exp_res.semesters));
          if (cycle_found_o !== exp_res.cycle_found)
            report_mismatch($sformatf("cycle_found got %0b exp %0b",
                                      cycle_found_o, exp_res.cycle_found));
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Directed cases: extremes, self-loop, duplicates, out-of-range labels, empty.
  task automatic test_directed();
    write_node_count(1);
    send_edge(0, 0, 1'b0, 1'b1);                 // empty graph gives 1
    send_edge(1, 1, 1'b1, 1'b1);                 // self-loop
    write_node_count(0);
    send_edge(1, 1, 1'b1, 1'b1);                 // no nodes: edge ignored
    write_node_count(64);
    send_edge(1, 2, 1'b1, 1'b0);
    send_edge(1, 2, 1'b1, 1'b0);                 // duplicate collapses
    send_edge(2, 64, 1'b1, 1'b0);
    send_edge(64, 0, 1'b1, 1'b0);                // label zero ignored
    send_edge(127, 3, 1'b1, 1'b0);               // label above count ignored
    send_edge(3, 127, 1'b1, 1'b1);
    send_edge(64, 1, 1'b1, 1'b0);
    send_edge(1, 64, 1'b1, 1'b1);                // two-node cycle
    write_node_count(127);                       // clamps to 64 nodes
    for (int i = 1; i < 64; i++) send_edge(i, i + 1, 1'b1, i == 63);
    write_node_count(5);
    send_edge(5, 6, 1'b1, 1'b0);
    send_edge(4, 5, 1'b1, 1'b1);
  endtask

  // Random graphs: mostly acyclic (edges low label to high), some with back arcs.
  task automatic test_random_graphs(input int beats);
    int sent;
    int len;
    int a;
    int b;
    int n;
    bit dag;
    sent = 0;
    while (sent < beats) begin
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0: write_node_count($urandom_range(1, 8));
          1: write_node_count($urandom_range(9, 64));
          2: write_node_count(64);
          default: write_node_count($urandom_range(0, 127));
        endcase
      end
      n = (node_cnt > NMax) ? NMax : ((node_cnt == 0) ? 1 : node_cnt);
      len = $urandom_range(0, 30);
      dag = ($urandom_range(3) != 0);
      for (int k = 0; k <= len; k++) begin
        a = $urandom_range(1, n);
        b = $urandom_range(1, n);
        if (dag && a >= b) begin
          a = (a == b) ? ((a > 1) ? a - 1 : a) : b;
          b = (a < n) ? $urandom_range(a + 1, n) : a;
          if (a == b) a = a - 1;
        end
        if ($urandom_range(15) == 0) a = $urandom_range(0, 127);
        if ($urandom_range(15) == 0) b = $urandom_range(0, 127);
        send_edge(a, b, $urandom_range(9) != 0, k == len);
        sent++;
      end
    end
  endtask

  // Hold the sender until the unit has returned everything, then resume.
  task automatic test_quiet_gap();
    drain_results();
    send_edge(1, 1, 1'b0, 1'b1);
  endtask

  initial begin
    mismatch_cnt = 0;
    node_cnt = 1;
    foreach (arc_rows[i]) arc_rows[i] = '0;
    send_idle_pct = 31;
    recv_idle_pct = 77;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_graphs(600);
    test_quiet_gap();
    send_idle_pct = 77;
    recv_idle_pct = 31;
    test_random_graphs(600);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_graphs(650);
    drain_results();
    repeat (200) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
